[sv/okq_pkg.sv]
// okq_pkg: shared types, field widths and operation/status codes of the
// ordered key queue
// depends on nothing; used by okq_ctrl, okq_cells and ordered_key_queue
package okq_pkg;

	// default queue capacity
	localparam int DEPTH_DEFAULT = 16;

	// field widths
	localparam int KEY_W     = 31;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int FIELD_W   = 5;

	// stream widths, padded to whole bytes
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 8;
	localparam int M_TDATA_W = 16;

	// request operations
	typedef enum logic [KIND_W-1:0] {
		KIND_APPEND = 2'd0,
		KIND_SEARCH = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // latch request and compare key against all cells
		logic apply;  // update cells and count, load result register
	} cmd_t;

endpackage

[sv/ordered_key_queue.sv]
// Ordered key queue: keeps up to QUEUE_DEPTH 31-bit keys in arrival order.
// Each request beat appends a key at the tail, searches for the first equal
// key, or removes the first equal key and closes the gap; each request gives
// one result beat with status, 1-based position and the entry count after
// the operation (position and count are reported in 5 bits). The accepting
// edge compares the key against every cell of the key chain in parallel; once
// the result register is free, the chain is shifted, the count updated and
// the result register loaded. One request is in flight at a time; the
// next request is taken while a result beat still waits on the master side,
// and its update is held until that beat is taken. No clearing pass is
// needed after reset.
// depends on okq_pkg, okq_ctrl, okq_cells
module ordered_key_queue #(
	parameter int QUEUE_DEPTH = okq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [okq_pkg::S_TDATA_W-1:0] s_tdata,  // [30:0] key
	input  logic [okq_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [okq_pkg::M_TDATA_W-1:0] m_tdata   // [1:0] status, [6:2] position,
	                                                // [11:7] count
);

	okq_pkg::cmd_t cmd;

	// request sequencer
	okq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// key chain and result register
	okq_cells #(
		.Depth (QUEUE_DEPTH)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_kind (s_tuser[okq_pkg::KIND_W-1:0]),
		.req_key  (s_tdata[okq_pkg::KEY_W-1:0]),
		.result   (m_tdata)
	);

endmodule

[sv/okq_ctrl.sv]
// okq_ctrl: request sequencer of the ordered key queue
// owns the stream handshakes and issues commands to okq_cells
// depends on okq_pkg
module okq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output okq_pkg::cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;
	logic   slot_free;

	// result register can take a new beat
	assign slot_free = !m_tvalid_q || m_tready;

	// commands
	always_comb begin
		cmd.load  = s_tvalid && s_tready_q;
		cmd.apply = (state_q == ST_EXEC) && slot_free;
	end

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// waiting result beat taken
					if (m_tvalid_q && m_tready) begin
						m_tvalid_q <= 1'b0;
					end
					if (s_tvalid && s_tready_q) begin
						state_q    <= ST_EXEC;
						s_tready_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					// a held result beat is never taken here without a new one loaded
					if (slot_free) begin
						m_tvalid_q <= 1'b1;
						s_tready_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;

endmodule

[sv/okq_cells.sv]
// okq_cells: datapath of the ordered key queue, a chain of key cells with
// one comparator per cell, the fill count and the result register
// depends on okq_pkg
module okq_cells #(
	parameter int Depth = okq_pkg::DEPTH_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  okq_pkg::cmd_t                 cmd,
	input  logic [okq_pkg::KIND_W-1:0]    req_kind,
	input  logic [okq_pkg::KEY_W-1:0]     req_key,
	output logic [okq_pkg::M_TDATA_W-1:0] result
);

	localparam int IW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);

	logic [okq_pkg::KEY_W-1:0] cell_q [Depth];
	logic [CW-1:0]             count_q;
	logic [okq_pkg::KIND_W-1:0] kind_q;
	logic [okq_pkg::KEY_W-1:0] key_q;
	logic [Depth-1:0]          hit_q;
	logic [okq_pkg::M_TDATA_W-1:0] result_q;

	logic [Depth-1:0]          first_oh;
	logic [Depth-1:0]          shift_mask;
	logic                      found;
	logic [IW-1:0]             hit_idx;
	logic                      full;
	logic                      do_append;
	logic                      do_remove;
	logic [okq_pkg::STATUS_W-1:0] res_status;
	logic [okq_pkg::FIELD_W-1:0]  res_pos;
	logic [CW-1:0]             next_count;

	// latch request, compare incoming key against every valid cell
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req_kind;
			key_q  <= req_key;
			for (int i = 0; i < Depth; i++) begin
				hit_q[i] <= (cell_q[i] == req_key) && (CW'(i) < count_q);
			end
		end
	end

	// first match nearest the head and the cells at or behind it
	always_comb begin
		first_oh   = hit_q & (~hit_q + Depth'(1));
		found      = |hit_q;
		shift_mask = found ? ~(first_oh - Depth'(1)) : '0;
		hit_idx    = '0;
		for (int i = 0; i < Depth; i++) begin
			if (first_oh[i]) begin
				hit_idx = hit_idx | IW'(i);
			end
		end
	end

	// operation decode and result fields
	always_comb begin
		full       = (count_q == CW'(Depth));
		do_append  = (kind_q == okq_pkg::KIND_APPEND) && !full;
		do_remove  = (kind_q == okq_pkg::KIND_REMOVE) && found;
		res_status = okq_pkg::STAT_NOT_FOUND;
		res_pos    = '0;
		next_count = count_q;
		unique case (kind_q)
			okq_pkg::KIND_APPEND: begin
				if (full) begin
					res_status = okq_pkg::STAT_FULL;
				end else begin
					res_status = okq_pkg::STAT_DONE;
					next_count = count_q + CW'(1);
					res_pos    = okq_pkg::FIELD_W'(next_count);
				end
			end
			okq_pkg::KIND_SEARCH, okq_pkg::KIND_REMOVE: begin
				if (found) begin
					res_status = okq_pkg::STAT_DONE;
					res_pos    = okq_pkg::FIELD_W'({1'b0, hit_idx} + (IW + 1)'(1));
					if (kind_q == okq_pkg::KIND_REMOVE) begin
						next_count = count_q - CW'(1);
					end
				end
			end
			default: begin
				res_status = okq_pkg::STAT_NOT_FOUND;
			end
		endcase
	end

	// cell chain: write at tail on append, close the gap on remove
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (do_append) begin
				cell_q[count_q[IW-1:0]] <= key_q;
			end else if (do_remove) begin
				for (int i = 0; i < Depth - 1; i++) begin
					if (shift_mask[i]) begin
						cell_q[i] <= cell_q[i + 1];
					end
				end
			end
		end
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.apply) begin
			count_q <= next_count;
		end
	end

	// result register: status, position, count from the lowest bit up
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			result_q <= okq_pkg::M_TDATA_W'({okq_pkg::FIELD_W'(next_count), res_pos,
				res_status});
		end
	end

	assign result = result_q;

endmodule

[sim/ordered_key_queue_tb.sv]
// ordered_key_queue_tb: self-checking testbench for the ordered key queue; a directed
// table of requests and about 1750 random requests with random idling on both streams
// depends on okq_pkg and ordered_key_queue (with okq_ctrl, okq_cells)
`timescale 1ns / 100ps

module ordered_key_queue_tb;

	localparam int QUEUE_DEPTH = okq_pkg::DEPTH_DEFAULT;
	localparam int CLK_HALF    = 4;
	localparam int RANDOM_N    = 1750;
	localparam int DIRECTED_N  = 25;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int GAP_MAX     = 14;

	localparam int KIND_W    = okq_pkg::KIND_W;
	localparam int KEY_W     = okq_pkg::KEY_W;
	localparam int STATUS_W  = okq_pkg::STATUS_W;
	localparam int FIELD_W   = okq_pkg::FIELD_W;
	localparam int S_TDATA_W = okq_pkg::S_TDATA_W;
	localparam int S_TUSER_W = okq_pkg::S_TUSER_W;
	localparam int M_TDATA_W = okq_pkg::M_TDATA_W;

	// request kinds and status codes
	localparam logic [KIND_W-1:0]   K_APPEND   = okq_pkg::KIND_APPEND;
	localparam logic [KIND_W-1:0]   K_SEARCH   = okq_pkg::KIND_SEARCH;
	localparam logic [KIND_W-1:0]   K_REMOVE   = okq_pkg::KIND_REMOVE;
	localparam logic [STATUS_W-1:0] S_DONE     = okq_pkg::STAT_DONE;
	localparam logic [STATUS_W-1:0] S_NOTFOUND = okq_pkg::STAT_NOT_FOUND;
	localparam logic [STATUS_W-1:0] S_FULL     = okq_pkg::STAT_FULL;

	// request kind that the block does not define
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	// directed rows carry either a typed expectation or defer to the predictor
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  position;
		logic [FIELD_W-1:0]  count;
	} queue_result_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [KEY_W-1:0]    key;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  position;
		logic [FIELD_W-1:0]  count;
	} request_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // [30:0] key
	logic [S_TUSER_W-1:0] s_tuser  = '0;  // [1:0] kind
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;        // [1:0] status, [6:2] position, [11:7] count

	// shadow copy of the queue contents, head at index 0
	logic [KEY_W-1:0] shadow_keys [QUEUE_DEPTH];
	int               shadow_fill = 0;

	queue_result_t pending_results [$];

	int  cycle_count   = 0;
	int  mismatches    = 0;
	int  results_seen  = 0;
	int  appends_done  = 0;
	int  appends_full  = 0;
	int  lookups_hit   = 0;
	int  lookups_miss  = 0;
	int  unused_kinds  = 0;
	bit  source_burst  = 1'b0;
	bit  sink_burst    = 1'b0;

	// directed requests: empty queue, extreme keys, duplicates, fill to full
	request_row_t directed_rows [DIRECTED_N] = '{
		'{K_SEARCH,    31'h0000_0000, TYPED,     S_NOTFOUND, 5'd0, 5'd0},
		'{K_REMOVE,    31'h0000_0000, TYPED,     S_NOTFOUND, 5'd0, 5'd0},
		'{KIND_UNUSED, 31'h7FFF_FFFF, TYPED,     S_NOTFOUND, 5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0000, TYPED,     S_DONE,     5'd1, 5'd1},
		'{K_APPEND,    31'h7FFF_FFFF, TYPED,     S_DONE,     5'd2, 5'd2},
		'{K_APPEND,    31'h0000_0000, TYPED,     S_DONE,     5'd3, 5'd3},
		'{K_SEARCH,    31'h0000_0000, TYPED,     S_DONE,     5'd1, 5'd3},
		'{K_REMOVE,    31'h0000_0000, TYPED,     S_DONE,     5'd1, 5'd2},
		'{K_SEARCH,    31'h0000_0000, TYPED,     S_DONE,     5'd2, 5'd2},
		'{K_APPEND,    31'h0000_0001, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0002, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0003, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0004, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0005, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0006, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0007, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0008, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_0009, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_000A, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_000B, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0000_000C, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h2AAA_AAAA, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h5555_5555, PREDICTED, S_DONE,     5'd0, 5'd0},
		'{K_APPEND,    31'h0001_2345, TYPED,     S_FULL,     5'd0, 5'd16},
		'{K_REMOVE,    31'h7FFF_FFFF, TYPED,     S_DONE,     5'd1, 5'd15}
	};

	ordered_key_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #CLK_HALF clk = ~clk;

	// cycle watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// applies one request to the shadow queue and returns its result
	function automatic queue_result_t apply_request(input logic [KIND_W-1:0] kind,
			input logic [KEY_W-1:0] key);
		queue_result_t res;
		int hit;
		int i;
		res.status   = S_NOTFOUND;
		res.position = '0;
		hit = -1;
		for (i = 0; i < shadow_fill; i++) begin
			if (hit < 0 && shadow_keys[i] == key)
				hit = i;
		end
		if (kind == K_APPEND) begin
			if (shadow_fill >= QUEUE_DEPTH) begin
				res.status = S_FULL;
			end else begin
				shadow_keys[shadow_fill] = key;
				shadow_fill++;
				res.status   = S_DONE;
				res.position = FIELD_W'(shadow_fill);
			end
		end else if (kind == K_SEARCH) begin
			if (hit >= 0) begin
				res.status   = S_DONE;
				res.position = FIELD_W'(hit + 1);
			end
		end else if (kind == K_REMOVE) begin
			if (hit >= 0) begin
				// close the gap, order kept
				for (i = hit; i + 1 < shadow_fill; i++)
					shadow_keys[i] = shadow_keys[i + 1];
				shadow_fill--;
				res.status   = S_DONE;
				res.position = FIELD_W'(hit + 1);
			end
		end
		res.count = FIELD_W'(shadow_fill);
		return res;
	endfunction

	// idle cycles before the next beat; bursts run with none
	function automatic int draw_gap(input bit burst);
		if (burst)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	// drives one request beat, waits for it to be taken, records the expected result
	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
			input bit typed, input queue_result_t typed_result);
		int gap;
		queue_result_t predicted;
		gap = draw_gap(source_burst);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - KEY_W){1'b0}}, key};
		s_tuser  <= {{(S_TUSER_W - KIND_W){1'b0}}, kind};
		do @(posedge clk); while (!s_tready);
		predicted = apply_request(kind, key);
		pending_results.push_back(typed ? typed_result : predicted);
		// tally what the run touched
		if (kind == KIND_UNUSED)
			unused_kinds++;
		else if (predicted.status == S_FULL)
			appends_full++;
		else if (kind == K_APPEND)
			appends_done++;
		else if (predicted.status == S_DONE)
			lookups_hit++;
		else
			lookups_miss++;
	endtask

	// key for a random request: often a present key, else a small pool or any value
	function automatic logic [KEY_W-1:0] draw_key(input bit prefer_present);
		if (prefer_present && shadow_fill > 0 && $urandom_range(0, 3) != 0)
			return shadow_keys[$urandom_range(0, shadow_fill - 1)];
		if ($urandom_range(0, 1) == 0)
			return KEY_W'($urandom_range(0, 23));
		return KEY_W'($urandom());
	endfunction

	// result side: random stalls, compare each beat with the oldest expectation
	initial begin
		int stall;
		queue_result_t got;
		queue_result_t want;
		wait (arst_n);
		forever begin
			if (results_seen % 50 == 0)
				sink_burst = ($urandom_range(0, 3) == 0);
			stall = draw_gap(sink_burst);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
			got.status   = m_tdata[1:0];
			got.position = m_tdata[6:2];
			got.count    = m_tdata[11:7];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result beat: status %0d position %0d count %0d",
						got.status, got.position, got.count);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"result %0d mismatch: expected status %0d position %0d ",
							"count %0d, got status %0d position %0d count %0d"},
							results_seen, want.status, want.position, want.count,
							got.status, got.position, got.count);
				end
			end
		end
	end

	// request side: reset, directed table, random requests, drain
	initial begin
		int n;
		int roll;
		int append_pct;
		logic [KIND_W-1:0] kind;
		queue_result_t typed_result;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_N; n++) begin
			typed_result.status   = directed_rows[n].status;
			typed_result.position = directed_rows[n].position;
			typed_result.count    = directed_rows[n].count;
			send_request(directed_rows[n].kind, directed_rows[n].key,
				directed_rows[n].typed, typed_result);
		end

		// random part: phases lean toward filling or draining the queue
		append_pct = 45;
		for (n = 0; n < RANDOM_N; n++) begin
			if (n % 40 == 0) begin
				append_pct   = 20 + 25 * $urandom_range(0, 2);
				source_burst = ($urandom_range(0, 3) == 0);
			end
			roll = $urandom_range(0, 99);
			if (roll < 3)
				kind = KIND_UNUSED;
			else if (roll < append_pct)
				kind = K_APPEND;
			else if (roll < append_pct + (100 - append_pct) / 2)
				kind = K_SEARCH;
			else
				kind = K_REMOVE;
			send_request(kind, draw_key(kind != K_APPEND), PREDICTED, '0);
		end
		s_tvalid <= 1'b0;

		// drain, then allow a few cycles for stray beats
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("%0d requests in %0d cycles: %0d appends, %0d refused as full, %0d hits,",
			DIRECTED_N + RANDOM_N, cycle_count, appends_done, appends_full, lookups_hit);
		$display("%0d misses, %0d unused kinds; %0d results checked, %0d mismatches",
			lookups_miss, unused_kinds, results_seen, mismatches);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
